// ===== src/urlpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package urlpd_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [7:0] MAX_OUT_CHARS_RESET = 8'd127;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MARK  = 8'h3f;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_END  = 8'h7f;
  localparam logic [3:0] HEX_ALPHA  = 4'd10;

  localparam logic REG_MAX_OUT_CHARS = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      nchar;
    logic            eos;
  } run_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h61 + {4'd0, HEX_ALPHA};
    end else begin
      d = b - 8'h41 + {4'd0, HEX_ALPHA};
    end
    hex_val = d[3:0];
  endfunction

  function automatic logic [7:0] printable(input logic [7:0] b);
    printable = (b >= PRINT_LO && b < PRINT_END) ? b : CHAR_MARK;
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] b);
    plain_map = (b == CHAR_PLUS) ? CHAR_SPACE : printable(b);
  endfunction

endpackage

`default_nettype wire

// ===== src/urlpd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urlpd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        max_out_chars,
  input  wire logic [7:0]        in_byte,
  input  wire logic              is_last,
  input  wire logic              accept,
  output logic                   q_push,
  output urlpd_pkg::run_t        q_data
);

  urlpd_pkg::phase_t phase, phase_next, phase_mid;
  logic [7:0] held, held_next, held_mid;
  logic [7:0] count, count_next;

  logic [3:0][7:0] cand;
  logic [2:0]      len;
  logic [1:0]      k;
  logic [7:0]      avail;
  logic            hb, pct_req, pct_ok, set_held, close, zero_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= urlpd_pkg::PH_IDLE;
      held  <= 8'd0;
      count <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
      count <= count_next;
    end
  end

  always_comb begin
    cand      = '0;
    len       = 3'd0;
    pct_req   = 1'b0;
    set_held  = 1'b0;
    zero_byte = (in_byte == 8'd0);
    hb        = urlpd_pkg::is_hex(in_byte);
    avail     = (count < max_out_chars) ? (max_out_chars - count) : 8'd0;

    case (phase)
      urlpd_pkg::PH_IDLE: begin
        if (in_byte == urlpd_pkg::CHAR_PCT) begin
          pct_req = 1'b1;
        end else begin
          cand[0] = urlpd_pkg::plain_map(in_byte);
          len     = 3'd1;
        end
      end
      urlpd_pkg::PH_PCT: begin
        if (hb) begin
          set_held = 1'b1;
        end else begin
          cand[0] = urlpd_pkg::CHAR_PCT;
          len     = 3'd1;
          if (in_byte == urlpd_pkg::CHAR_PCT) begin
            pct_req = 1'b1;
          end else begin
            cand[1] = urlpd_pkg::plain_map(in_byte);
            len     = 3'd2;
          end
        end
      end
      urlpd_pkg::PH_DIG: begin
        if (hb) begin
          cand[0] = urlpd_pkg::printable({urlpd_pkg::hex_val(held),
                                          urlpd_pkg::hex_val(in_byte)});
          len     = 3'd1;
        end else begin
          cand[0] = urlpd_pkg::CHAR_PCT;
          cand[1] = held;
          len     = 3'd2;
          if (in_byte == urlpd_pkg::CHAR_PCT) begin
            pct_req = 1'b1;
          end else begin
            cand[2] = urlpd_pkg::plain_map(in_byte);
            len     = 3'd3;
          end
        end
      end
      default: begin
        len = 3'd0;
      end
    endcase

    if (zero_byte) begin
      cand     = '0;
      len      = 3'd0;
      pct_req  = 1'b0;
      set_held = 1'b0;
    end

    pct_ok   = pct_req && ({5'd0, len} < avail);
    held_mid = set_held ? in_byte : held;
    if (pct_ok) begin
      phase_mid = urlpd_pkg::PH_PCT;
    end else if (set_held) begin
      phase_mid = urlpd_pkg::PH_DIG;
    end else if (zero_byte) begin
      phase_mid = phase;
    end else begin
      phase_mid = urlpd_pkg::PH_IDLE;
    end

    close = zero_byte || is_last;
    if (close && phase_mid != urlpd_pkg::PH_IDLE) begin
      cand[len[1:0]] = urlpd_pkg::CHAR_PCT;
      len            = len + 3'd1;
      if (phase_mid == urlpd_pkg::PH_DIG) begin
        cand[len[1:0]] = held_mid;
        len            = len + 3'd1;
      end
    end

    k = ({5'd0, len} <= avail) ? len[1:0] : avail[1:0];

    if (close) begin
      phase_next = urlpd_pkg::PH_IDLE;
      held_next  = 8'd0;
      count_next = 8'd0;
    end else begin
      phase_next = phase_mid;
      held_next  = held_mid;
      count_next = count + {6'd0, k};
    end

    q_data.chars = cand[2:0];
    q_data.nchar = k;
    q_data.eos   = close;
    q_push       = accept && (k != 2'd0 || close);
  end

endmodule

`default_nettype wire

// ===== src/urlpd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urlpd_queue #(
  parameter int DEPTH = urlpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire urlpd_pkg::run_t   wr_data,
  output logic                   full,
  input  wire logic              pop,
  output urlpd_pkg::run_t        rd_data,
  output logic                   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  urlpd_pkg::run_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign full    = (fill == FULL_CNT);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/urlpd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urlpd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire urlpd_pkg::run_t   q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_byte,
  output logic                   end_of_string,
  output logic                   last_of_run
);

  urlpd_pkg::run_t cur;
  logic            cur_valid;
  logic [1:0]      idx;
  logic [2:0]      nres;
  logic            at_last, take;
  logic [7:0]      sel;

  assign nres    = {1'b0, cur.nchar} + {2'd0, cur.eos};
  assign at_last = ({1'b0, idx} == nres - 3'd1);
  assign take    = pop && cur_valid;
  assign q_pop   = !q_empty && (!cur_valid || (take && at_last));
  assign empty   = !cur_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_comb begin
    case (idx)
      2'd0:    sel = cur.chars[0];
      2'd1:    sel = cur.chars[1];
      2'd2:    sel = cur.chars[2];
      default: sel = 8'd0;
    endcase
    out_byte      = (idx < cur.nchar) ? sel : 8'd0;
    end_of_string = cur.eos && (idx == cur.nchar);
    last_of_run   = at_last;
  end

endmodule

`default_nettype wire

// ===== src/url_percent_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// input     in         push / full          in_byte, is_last
// result    out        pop / empty          out_byte, end_of_string, last_of_run
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// One input item is taken per cycle while full is low; it yields zero to four results, one per cycle.
// The result side drains one result per cycle while pop is high, so items of one result run at full rate.
// A queue of QUEUE_DEPTH runs sits between decode and output; full rises when it fills.
// Reset clears escape state, character count and queue; max_out_chars returns to 127.

module url_percent_decoder #(
  parameter int QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        is_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             end_of_string,
  output logic             last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]      max_out_chars;
  logic            accept, q_push, q_full, q_empty, q_pop;
  urlpd_pkg::run_t q_wr, q_rd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == urlpd_pkg::REG_MAX_OUT_CHARS) ? {24'd0, max_out_chars} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_chars <= urlpd_pkg::MAX_OUT_CHARS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == urlpd_pkg::REG_MAX_OUT_CHARS) begin
      max_out_chars <= pwdata[7:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  urlpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .max_out_chars (max_out_chars),
    .in_byte       (in_byte),
    .is_last       (is_last),
    .accept        (accept),
    .q_push        (q_push),
    .q_data        (q_wr)
  );

  urlpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  urlpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_rd),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .end_of_string (end_of_string),
    .last_of_run   (last_of_run)
  );

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_wr.nchar != 2'd0 || q_wr.eos))
    else $error("queued run carries no result");

  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_string) |-> (out_byte == 8'd0 && last_of_run))
    else $error("terminator result malformed");

  a_char_printable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !end_of_string) |-> (out_byte >= 8'h20 && out_byte < 8'h7f))
    else $error("character result not printable");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] ADDR_MAX_OUT = {urlpd_pkg::REG_MAX_OUT_CHARS, 2'b00};
  localparam logic [2:0] ADDR_UNUSED  = 3'd4;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       lor;
  } dec_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last_flag;
    logic       typed;
    logic [7:0] eb;
    logic       eeos;
  } row_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        is_last;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        end_of_string;
  logic        last_of_run;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        row_typed;
  logic [7:0]  row_exp_byte;
  logic        row_exp_eos;

  dec_t              decoded_q[$];
  dec_t              run_buf[4];
  int                run_n;
  logic [7:0]        cap_m;
  urlpd_pkg::phase_t esc_m;
  logic [7:0]        held_m;
  logic [7:0]        cnt_m;

  row_t        rows[$];
  int          err_count = 0;
  int          items_sent = 0;
  bit          tx_quiet = 1'b0;

  url_percent_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .is_last       (is_last),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .end_of_string (end_of_string),
    .last_of_run   (last_of_run),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("url_percent_decoder verification failed");
    $finish;
  end

  function automatic int nib(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] shown(input logic [7:0] b);
    return (b >= urlpd_pkg::PRINT_LO && b < urlpd_pkg::PRINT_END) ? b : urlpd_pkg::CHAR_MARK;
  endfunction

  task automatic put_res(input logic [7:0] ch, input logic eos);
    dec_t d;
    d.ch  = ch;
    d.eos = eos;
    d.lor = 1'b0;
    if (run_n < 4) begin
      run_buf[run_n] = d;
      run_n = run_n + 1;
    end
  endtask

  task automatic emit_ch(input logic [7:0] ch);
    if (cnt_m >= cap_m) return;
    put_res(ch, 1'b0);
    cnt_m = cnt_m + 8'd1;
  endtask

  task automatic feed(input logic [7:0] b);
    if (cnt_m >= cap_m) return;
    if (b == urlpd_pkg::CHAR_PCT) begin
      esc_m = urlpd_pkg::PH_PCT;
    end else if (b == urlpd_pkg::CHAR_PLUS) begin
      emit_ch(urlpd_pkg::CHAR_SPACE);
    end else begin
      emit_ch(shown(b));
    end
  endtask

  task automatic decode_item(input logic [7:0] b, input logic last_flag);
    int lo;
    int hi;
    logic [7:0] v;
    urlpd_pkg::phase_t ph;
    run_n = 0;
    if (b != 8'h00) begin
      case (esc_m)
        urlpd_pkg::PH_PCT: begin
          if (nib(b) >= 0) begin
            held_m = b;
            esc_m = urlpd_pkg::PH_DIG;
          end else begin
            esc_m = urlpd_pkg::PH_IDLE;
            emit_ch(urlpd_pkg::CHAR_PCT);
            feed(b);
          end
        end
        urlpd_pkg::PH_DIG: begin
          lo = nib(b);
          hi = nib(held_m);
          esc_m = urlpd_pkg::PH_IDLE;
          if (lo >= 0 && hi >= 0) begin
            v = 8'(hi * 16 + lo);
            emit_ch(shown(v));
          end else begin
            emit_ch(urlpd_pkg::CHAR_PCT);
            feed(held_m);
            feed(b);
          end
        end
        default: feed(b);
      endcase
    end
    if (b == 8'h00 || last_flag) begin
      ph = esc_m;
      esc_m = urlpd_pkg::PH_IDLE;
      if (ph != urlpd_pkg::PH_IDLE) begin
        emit_ch(urlpd_pkg::CHAR_PCT);
        if (ph == urlpd_pkg::PH_DIG) feed(held_m);
      end
      esc_m = urlpd_pkg::PH_IDLE;
      put_res(8'h00, 1'b1);
      held_m = 8'h00;
      cnt_m = 8'h00;
    end
  endtask

  task automatic miss(input string msg);
    err_count = err_count + 1;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : result_check
    dec_t d;
    int i;
    if (rst) begin
      cap_m  = urlpd_pkg::MAX_OUT_CHARS_RESET;
      esc_m  = urlpd_pkg::PH_IDLE;
      held_m = 8'h00;
      cnt_m  = 8'h00;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_MAX_OUT) cap_m = pwdata[7:0];
        end else if (prdata !== {24'd0, cap_m}) begin
          miss($sformatf("prdata mismatch: expected %h actual %h", {24'd0, cap_m}, prdata));
        end
      end
      if (push && !full) begin
        decode_item(in_byte, is_last);
        if (row_typed) begin
          d.ch  = row_exp_byte;
          d.eos = row_exp_eos;
          d.lor = 1'b1;
          decoded_q.push_back(d);
        end else begin
          for (i = 0; i < run_n; i++) begin
            d = run_buf[i];
            d.lor = (i == run_n - 1);
            decoded_q.push_back(d);
          end
        end
      end
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          miss($sformatf("unexpected transfer: byte %h eos %b last %b",
                         out_byte, end_of_string, last_of_run));
        end else begin
          d = decoded_q.pop_front();
          if ({out_byte, end_of_string, last_of_run} !== {d.ch, d.eos, d.lor}) begin
            miss($sformatf({"mismatch: expected byte %h eos %b last %b, ",
                            "actual byte %h eos %b last %b"},
                           d.ch, d.eos, d.lor, out_byte, end_of_string, last_of_run));
          end
        end
      end
    end
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'('h30 + r);
    if (r < 16) return 8'('h61 + r - 10);
    return 8'('h41 + r - 16);
  endfunction

  task automatic add_row(input logic [7:0] b, input logic last_flag, input logic typed,
                         input logic [7:0] eb, input logic eeos);
    row_t r;
    r.b = b;
    r.last_flag = last_flag;
    r.typed = typed;
    r.eb = eb;
    r.eeos = eeos;
    rows.push_back(r);
  endtask

  task automatic send_item(input logic [7:0] b, input logic last_flag, input logic typed,
                           input logic [7:0] eb, input logic eeos);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_byte      <= b;
    is_last      <= last_flag;
    row_typed    <= typed;
    row_exp_byte <= eb;
    row_exp_eos  <= eeos;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  task automatic wait_drained();
    push      <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] a, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_string();
    logic [7:0] s[$];
    int len;
    int i;
    int t;
    bit by_last;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    for (i = 0; i < len; i++) begin
      t = $urandom_range(0, 99);
      if (t < 45) begin
        s.push_back(8'($urandom_range(8'h20, 8'h7e)));
      end else if (t < 60) begin
        s.push_back(urlpd_pkg::CHAR_PLUS);
      end else if (t < 85) begin
        s.push_back(urlpd_pkg::CHAR_PCT);
        s.push_back(rand_hex());
        s.push_back(rand_hex());
      end else if (t < 92) begin
        s.push_back(urlpd_pkg::CHAR_PCT);
        if ($urandom_range(0, 1)) s.push_back(rand_hex());
        s.push_back(8'($urandom_range(1, 255)));
      end else begin
        s.push_back(8'($urandom_range(1, 255)));
      end
    end
    by_last = (s.size() > 0) && $urandom_range(0, 1);
    if (!by_last) s.push_back(8'h00);
    for (i = 0; i < s.size(); i++) begin
      if (i == s.size() - 1) begin
        send_item(s[i], by_last ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, 8'h00, 1'b0);
      end else begin
        send_item(s[i], 1'b0, 1'b0, 8'h00, 1'b0);
      end
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                         1'b0, 8'h00, 1'b0);
  endtask

  initial begin
    pop = 1'b0;
    @(posedge clk);
    forever begin : drain_drive
      int n;
      pop <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      n = pick_gap(1'b0);
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int i;
    int p;
    int budget;
    logic [7:0] cap;
    bit paused;
    rst          = 1'b1;
    push         = 1'b0;
    in_byte      = 8'h00;
    is_last      = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 3'd0;
    pwdata       = 32'd0;
    row_typed    = 1'b0;
    row_exp_byte = 8'h00;
    row_exp_eos  = 1'b0;
    paused       = 1'b0;

    // byte  last typed exp  eos
    add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1);
    add_row(8'hff, 1'b0, 1'b1, 8'h3f, 1'b0);
    add_row(8'h7f, 1'b0, 1'b1, 8'h3f, 1'b0);
    add_row(8'h1f, 1'b0, 1'b1, 8'h3f, 1'b0);
    add_row(8'h20, 1'b0, 1'b1, 8'h20, 1'b0);
    add_row(8'h7e, 1'b0, 1'b1, 8'h7e, 1'b0);
    add_row(8'h2b, 1'b0, 1'b1, 8'h20, 1'b0);
    add_row(8'h01, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h34, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h31, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h66, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h46, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h33, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h7a, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h32, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h61, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h34, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h78, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(8'h25, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_access(1'b0, ADDR_MAX_OUT, 32'd0);
    for (i = 0; i < rows.size(); i++) begin
      send_item(rows[i].b, rows[i].last_flag, rows[i].typed, rows[i].eb, rows[i].eeos);
    end
    wait_drained();

    cfg_access(1'b1, ADDR_UNUSED, 32'h0000_0009);
    cfg_access(1'b0, ADDR_MAX_OUT, 32'd0);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: cap = 8'd1;
        1: cap = 8'd255;
        2: cap = 8'd0;
        3: cap = 8'd2;
        4: cap = 8'($urandom_range(3, 20));
        5: cap = 8'($urandom_range(1, 255));
        6: cap = 8'd5;
        default: cap = 8'd127;
      endcase
      cfg_access(1'b1, ADDR_MAX_OUT, {24'd0, cap});
      cfg_access(1'b0, ADDR_MAX_OUT, 32'd0);
      tx_quiet = ($urandom_range(0, 3) == 0);
      budget = items_sent + ((cap == 8'd0) ? 20 : 34);
      while (items_sent < budget) begin
        if (p == 3 && !paused && items_sent >= budget - 20) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          send_string();
        end else begin
          send_noise();
        end
      end
      wait_drained();
    end

    if (decoded_q.size() != 0) miss("expected transfers left over at end of run");
    if (err_count == 0) begin
      $display("url_percent_decoder verification clean");
    end else begin
      $display("url_percent_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/urlpd_pkg.sv
src/urlpd_front.sv
src/urlpd_queue.sv
src/urlpd_back.sv
src/url_percent_decoder.sv
dv/tb.sv
